FILE: src/updm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// updm_pkg - shared types and constants for the ungapped diagonal max filter
// Sizes of the cell row, transaction field layout, command struct and the
// saturating byte subtract used in every cell.
// ============================================================================
package updm_pkg;

   // Table sizes
   localparam int MAX_POSITIONS = 1024;
   localparam int ALPHABET_SIZE = 32;

   // Cell row: each cell owns a contiguous slice of profile positions
   localparam int NUM_CELLS  = 16;
   localparam int CELL_DEPTH = MAX_POSITIONS / NUM_CELLS;
   localparam int LOCAL_W    = $clog2(CELL_DEPTH);
   localparam int CELL_W     = $clog2(NUM_CELLS);
   localparam int ALPHA_W    = $clog2(ALPHABET_SIZE);
   localparam int SCORE_DEPTH = ALPHABET_SIZE * CELL_DEPTH;

   // Transaction field widths
   localparam int POS_W  = 10;
   localparam int RES_W  = 5;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 11;

   // req_tdata layout, lowest bit first: position, residue, score_byte
   localparam int TD_POS_LSB  = 0;
   localparam int TD_RES_LSB  = TD_POS_LSB + POS_W;
   localparam int TD_BYTE_LSB = TD_RES_LSB + RES_W;
   localparam int REQ_TDATA_W = ((TD_BYTE_LSB + BYTE_W + 7) / 8) * 8;

   // Operation codes carried on req_tuser
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_RESIDUE = 1'b1;

   // Diagonal start value and length register reset
   localparam logic [BYTE_W-1:0] START_VALUE = 8'h80;
   localparam logic [LEN_W-1:0]  LEN_RESET   = 11'd1024;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic               sweep;      // issue read of local entry idx
      logic               init;       // clearing pass: write start value
      logic               last;       // final residue: write start value back
      logic               res_ok;     // residue inside the alphabet
      logic [LOCAL_W-1:0] idx;        // local entry (sweep or load)
      logic [RES_W-1:0]   residue;    // residue code (sweep or load)
      logic [LEN_W-1:0]   len;        // positions in use
      logic               load;       // write one score byte
      logic [CELL_W-1:0]  load_cell;  // cell that takes the load
      logic [BYTE_W-1:0]  load_byte;  // score byte to store
      logic               fold;       // pass running max to the right
      logic               clear_max;  // return running max to start value
   } cmd_type;

   // Signed 8-bit saturating subtract on raw bytes
   function automatic logic [BYTE_W-1:0] sat_sub8(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
      logic signed [BYTE_W:0] d;
      logic [BYTE_W-1:0]      r;
      begin
         d = $signed({a[BYTE_W-1], a}) - $signed({b[BYTE_W-1], b});
         if (d > 9'sd127) begin
            r = 8'h7F;
         end else if (d < -9'sd128) begin
            r = 8'h80;
         end else begin
            r = d[BYTE_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

FILE: src/updm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// updm_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module updm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/updm_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// updm_cell - one slice of profile positions
// Holds the score bytes and diagonal bytes of its slice, sweeps them one
// entry a cycle, hands its last diagonal and its running max to the right.
// ============================================================================
module updm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [updm_pkg::CELL_W-1:0]   cell_id,
   input  updm_pkg::cmd_type             cmd,
   input  logic [updm_pkg::BYTE_W-1:0]   left_tail,
   input  logic [updm_pkg::BYTE_W-1:0]   left_max,
   output logic [updm_pkg::BYTE_W-1:0]   tail,
   output logic [updm_pkg::BYTE_W-1:0]   max_score
);

   localparam logic [updm_pkg::LOCAL_W-1:0] LAST_IDX =
      updm_pkg::LOCAL_W'(updm_pkg::CELL_DEPTH - 1);

   logic [updm_pkg::BYTE_W-1:0] diag_rdata;
   logic [updm_pkg::BYTE_W-1:0] score_rdata;
   logic                        score_we;
   logic [updm_pkg::ALPHA_W+updm_pkg::LOCAL_W-1:0] score_addr;

   // Compute stage registers
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_init_ff, s1_last_ff, s1_res_ok_ff;
   logic [updm_pkg::LOCAL_W-1:0] s1_idx_ff;
   logic [updm_pkg::BYTE_W-1:0]  carry_ff, carry_in;
   logic [updm_pkg::BYTE_W-1:0]  tail_ff, tail_in;
   logic [updm_pkg::BYTE_W-1:0]  max_ff, max_in;

   logic [updm_pkg::BYTE_W-1:0]  prev;
   logic [updm_pkg::BYTE_W-1:0]  score;
   logic [updm_pkg::BYTE_W-1:0]  new_val;
   logic [updm_pkg::BYTE_W-1:0]  wr_val;
   logic [updm_pkg::CELL_W+updm_pkg::LOCAL_W-1:0] global_idx;
   logic                         active;

   // Score table slice: loads write, sweeps read
   assign score_we   = cmd.load && (cmd.load_cell == cell_id);
   assign score_addr = {cmd.residue[updm_pkg::ALPHA_W-1:0], cmd.idx};

   updm_ram #(
      .WIDTH (updm_pkg::BYTE_W),
      .DEPTH (updm_pkg::SCORE_DEPTH)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_addr),
      .wr_data (cmd.load_byte),
      .rd_addr (score_addr),
      .rd_data (score_rdata)
   );

   // Diagonal slice: read at issue, write back at compute
   updm_ram #(
      .WIDTH (updm_pkg::BYTE_W),
      .DEPTH (updm_pkg::CELL_DEPTH)
   ) u_diag_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_val),
      .rd_addr (cmd.idx),
      .rd_data (diag_rdata)
   );

   // Diagonal update for the entry in the compute stage
   always_comb begin
      s1_valid_in = cmd.sweep;
      prev        = (s1_idx_ff == '0) ? left_tail : carry_ff;
      score       = s1_res_ok_ff ? score_rdata : '0;
      new_val     = updm_pkg::sat_sub8(prev, score);
      global_idx  = {cell_id, s1_idx_ff};
      active      = 32'(global_idx) < 32'(cmd.len);

      if (s1_init_ff || s1_last_ff) begin
         wr_val = updm_pkg::START_VALUE;
      end else if (active) begin
         wr_val = new_val;
      end else begin
         wr_val = diag_rdata;
      end

      carry_in = s1_valid_ff ? diag_rdata : carry_ff;
      tail_in  = (s1_valid_ff && (s1_idx_ff == LAST_IDX)) ? wr_val : tail_ff;

      // Running max: track new values, fold toward the right end, clear
      max_in = max_ff;
      if (cmd.clear_max) begin
         max_in = updm_pkg::START_VALUE;
      end else if (cmd.fold) begin
         max_in = (left_max > max_ff) ? left_max : max_ff;
      end else if (s1_valid_ff && !s1_init_ff && active && (new_val > max_ff)) begin
         max_in = new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         tail_ff     <= updm_pkg::START_VALUE;
         max_ff      <= updm_pkg::START_VALUE;
      end else begin
         s1_valid_ff <= s1_valid_in;
         tail_ff     <= tail_in;
         max_ff      <= max_in;
      end
   end

   // Advance payload of the compute stage
   always_ff @(posedge clock) begin
      s1_idx_ff    <= cmd.idx;
      s1_init_ff   <= cmd.init;
      s1_last_ff   <= cmd.last;
      s1_res_ok_ff <= cmd.res_ok;
      carry_ff     <= carry_in;
   end

   assign tail      = tail_ff;
   assign max_score = max_ff;

endmodule

FILE: src/updm_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// updm_ctrl - transaction controller for the cell row
// Accepts load and residue transactions, sequences sweeps, clearing pass,
// max fold and the result register.
// ============================================================================
module updm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [updm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  logic [updm_pkg::LEN_W-1:0]        length,
   input  logic [updm_pkg::BYTE_W-1:0]       chain_max,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [updm_pkg::BYTE_W-1:0]       rsp_tdata,
   output updm_pkg::cmd_type                 cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [updm_pkg::LOCAL_W-1:0] LAST_IDX =
      updm_pkg::LOCAL_W'(updm_pkg::CELL_DEPTH - 1);
   localparam logic [updm_pkg::CELL_W-1:0] LAST_FOLD =
      updm_pkg::CELL_W'(updm_pkg::NUM_CELLS - 1);

   state_type                     state_ff, state_in;
   logic [updm_pkg::LOCAL_W-1:0]  idx_ff, idx_in;
   logic [updm_pkg::RES_W-1:0]    residue_ff, residue_in;
   logic                          last_ff, last_in;
   logic                          res_ok_ff, res_ok_in;
   logic                          load_ff, load_in;
   logic [updm_pkg::CELL_W-1:0]   load_cell_ff, load_cell_in;
   logic [updm_pkg::BYTE_W-1:0]   load_byte_ff, load_byte_in;
   logic [updm_pkg::CELL_W-1:0]   fold_cnt_ff, fold_cnt_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [updm_pkg::BYTE_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                          accept;
   logic                          emit_go;
   logic [updm_pkg::POS_W-1:0]    f_pos;
   logic [updm_pkg::RES_W-1:0]    f_res;
   logic [updm_pkg::BYTE_W-1:0]   f_byte;
   logic                          f_res_ok;
   logic                          f_pos_ok;

   // Unpack the request transaction
   assign f_pos    = req_tdata[updm_pkg::TD_POS_LSB  +: updm_pkg::POS_W];
   assign f_res    = req_tdata[updm_pkg::TD_RES_LSB  +: updm_pkg::RES_W];
   assign f_byte   = req_tdata[updm_pkg::TD_BYTE_LSB +: updm_pkg::BYTE_W];
   assign f_res_ok = 32'(f_res) < updm_pkg::ALPHABET_SIZE;
   assign f_pos_ok = 32'(f_pos) < updm_pkg::MAX_POSITIONS;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   // Next state and registered outputs
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      residue_in    = residue_ff;
      last_in       = last_ff;
      res_ok_in     = res_ok_ff;
      load_in       = 1'b0;
      load_cell_in  = load_cell_ff;
      load_byte_in  = load_byte_ff;
      fold_cnt_in   = fold_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      case (state_ff)
         ST_INIT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               residue_in = f_res;
               res_ok_in  = f_res_ok;
               if (req_tuser == updm_pkg::OP_LOAD) begin
                  // Hold the load for one cycle of table write
                  load_in      = f_res_ok && f_pos_ok;
                  idx_in       = f_pos[updm_pkg::LOCAL_W-1:0];
                  load_cell_in = f_pos[updm_pkg::LOCAL_W +: updm_pkg::CELL_W];
                  load_byte_in = f_byte;
               end else begin
                  idx_in   = '0;
                  last_in  = req_tlast;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = last_ff ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            fold_cnt_in = '0;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            fold_cnt_in = fold_cnt_ff + 1'b1;
            if (fold_cnt_ff == LAST_FOLD) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = chain_max;
               last_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         idx_ff        <= '0;
         last_ff       <= 1'b0;
         load_ff       <= 1'b0;
         fold_cnt_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         last_ff       <= last_in;
         load_ff       <= load_in;
         fold_cnt_ff   <= fold_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      residue_ff   <= residue_in;
      res_ok_ff    <= res_ok_in;
      load_cell_ff <= load_cell_in;
      load_byte_ff <= load_byte_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Broadcast command to the cell row
   always_comb begin
      cmd.sweep     = (state_ff == ST_SWEEP) || (state_ff == ST_INIT);
      cmd.init      = (state_ff == ST_INIT);
      cmd.last      = (state_ff == ST_SWEEP) && last_ff;
      cmd.res_ok    = res_ok_ff;
      cmd.idx       = idx_ff;
      cmd.residue   = residue_ff;
      cmd.len       = length;
      cmd.load      = load_ff;
      cmd.load_cell = load_cell_ff;
      cmd.load_byte = load_byte_ff;
      cmd.fold      = (state_ff == ST_FOLD);
      cmd.clear_max = emit_go;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: src/ungapped_profile_diagonal_max.sv
`timescale 1ns / 1ps
// ============================================================================
// ungapped_profile_diagonal_max - ungapped diagonal score maximum filter
// Load transactions fill a byte score profile; residue transactions update
// all diagonals across a row of 16 cells of 64 positions each.
// ============================================================================
// Load transaction: accept, then one table write. Residue transaction: accept, then
// a sweep of one local diagonal entry per cycle in every cell via one read port,
// with req_tready low until the sweep ends. A residue marked last adds a compute drain,
// a max fold along the cell row and the result register, which waits while a result is held.
// Reset: clearing pass of the diagonals with req_tready low;
// the score table holds no reset value and must be loaded before use.
module ungapped_profile_diagonal_max (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [updm_pkg::REQ_TDATA_W-1:0]  req_tdata,  // position, residue, score_byte
   input  logic                              req_tuser,  // operation
   input  logic                              req_tlast,  // last_residue
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [updm_pkg::BYTE_W-1:0]       rsp_tdata,  // max_score
   // Length register
   input  logic                              csr_wr_en,
   input  logic [updm_pkg::LEN_W-1:0]        csr_wr_data
);

   logic [updm_pkg::LEN_W-1:0]  length_ff, length_in;
   updm_pkg::cmd_type           cmd;
   logic [updm_pkg::BYTE_W-1:0] tail_w     [updm_pkg::NUM_CELLS];
   logic [updm_pkg::BYTE_W-1:0] max_w      [updm_pkg::NUM_CELLS];
   logic [updm_pkg::BYTE_W-1:0] left_tail_w[updm_pkg::NUM_CELLS];
   logic [updm_pkg::BYTE_W-1:0] left_max_w [updm_pkg::NUM_CELLS];

   // Length register
   assign length_in = csr_wr_en ? csr_wr_data : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= updm_pkg::LEN_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   updm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .length     (length_ff),
      .chain_max  (max_w[updm_pkg::NUM_CELLS-1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd)
   );

   // Cell row: each cell sees its left neighbor's tail diagonal and max
   for (genvar g = 0; g < updm_pkg::NUM_CELLS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_tail_w[g] = updm_pkg::START_VALUE;
         assign left_max_w[g]  = updm_pkg::START_VALUE;
      end else begin : g_link
         assign left_tail_w[g] = tail_w[g-1];
         assign left_max_w[g]  = max_w[g-1];
      end

      updm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (updm_pkg::CELL_W'(g)),
         .cmd       (cmd),
         .left_tail (left_tail_w[g]),
         .left_max  (left_max_w[g]),
         .tail      (tail_w[g]),
         .max_score (max_w[g])
      );
   end

endmodule

FILE: test/updm_max_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// updm_max_checker - scoreboard for the ungapped diagonal max filter
// Follows the request, result and length-register traffic of the block. It
// keeps its own score table, diagonal row and running maximum, queues the
// max_score due at the end of each sequence, and compares every accepted
// result transaction with the oldest queued value.
// ============================================================================
module updm_max_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [updm_pkg::REQ_TDATA_W-1:0]  req_tdata,  // position, residue, score_byte
   input  logic                              req_tuser,  // operation
   input  logic                              req_tlast,  // last_residue
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [updm_pkg::BYTE_W-1:0]       rsp_tdata,  // max_score
   input  logic                              csr_wr_en,
   input  logic [updm_pkg::LEN_W-1:0]        csr_wr_data,
   output int                                pending,
   output int                                mismatches
);
   import updm_pkg::*;

   logic [BYTE_W-1:0] score_rom [ALPHABET_SIZE][MAX_POSITIONS];
   logic [BYTE_W-1:0] diag_row [MAX_POSITIONS];
   logic [BYTE_W-1:0] seq_best;
   logic [LEN_W-1:0]  len_reg;
   logic [BYTE_W-1:0] max_due [$];
   int                fail_total;

   // Signed byte difference, clamped to the signed byte range
   function automatic logic [BYTE_W-1:0] sub_clamp(input logic [BYTE_W-1:0] lhs,
                                                   input logic [BYTE_W-1:0] rhs);
      int diff;
      diff = int'($signed(lhs)) - int'($signed(rhs));
      if (diff > 127) begin
         diff = 127;
      end else if (diff < -128) begin
         diff = -128;
      end
      return diff[BYTE_W-1:0];
   endfunction

   // Return diagonals and the running max to the start value
   function automatic void restart_sequence();
      for (int k = 0; k < MAX_POSITIONS; k++) begin
         diag_row[k] = START_VALUE;
      end
      seq_best = START_VALUE;
   endfunction

   // Shift every diagonal one position along, minus the residue's score
   function automatic void advance_diagonals(input logic [RES_W-1:0] res);
      int                span;
      logic [BYTE_W-1:0] from_left;
      logic [BYTE_W-1:0] held;
      span = (len_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(len_reg);
      from_left = START_VALUE;
      for (int k = 0; k < span; k++) begin
         held = diag_row[k];
         diag_row[k] = sub_clamp(from_left, score_rom[res][k]);
         if (diag_row[k] > seq_best) begin
            seq_best = diag_row[k];
         end
         from_left = held;
      end
   endfunction

   always @(posedge clock) begin : watch
      logic [POS_W-1:0]  req_pos;
      logic [RES_W-1:0]  req_res;
      logic [BYTE_W-1:0] req_byte;
      logic [BYTE_W-1:0] want;
      if (reset) begin
         restart_sequence();
         len_reg = LEN_RESET;
         max_due.delete();
         fail_total = 0;
      end else begin
         // Length register write
         if (csr_wr_en) begin
            len_reg = csr_wr_data;
         end

         // Request transaction: load a score or score one residue
         if (req_tvalid && req_tready) begin
            req_pos  = req_tdata[TD_POS_LSB +: POS_W];
            req_res  = req_tdata[TD_RES_LSB +: RES_W];
            req_byte = req_tdata[TD_BYTE_LSB +: BYTE_W];
            if (req_tuser == OP_LOAD) begin
               score_rom[req_res][req_pos] = req_byte;
            end else begin
               advance_diagonals(req_res);
               if (req_tlast) begin
                  max_due.push_back(seq_best);
                  restart_sequence();
               end
            end
         end

         // Result transaction: compare with the oldest sequence max
         if (rsp_tvalid && rsp_tready) begin
            if (max_due.size() == 0) begin
               $display("%0t max_score with no sequence finished: expected none, actual %0d",
                        $time, rsp_tdata);
               fail_total++;
            end else begin
               want = max_due.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t max_score mismatch: expected %0d, actual %0d",
                           $time, want, rsp_tdata);
                  fail_total++;
               end
            end
         end
      end
      pending    <= max_due.size();
      mismatches <= fail_total;
   end

endmodule

FILE: test/tb_ungapped_profile_diagonal_max.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ungapped_profile_diagonal_max - testbench for the diagonal max filter
// Loads score entries and streams residue sequences under several model
// lengths (zero, one, full and above the table among them), with random
// back-pressure and gaps on both channels and one long result stall. Only
// score entries that were loaded are ever read. A separate checker predicts
// and compares every result; this module drives stimulus and gives the verdict.
// ============================================================================
module tb_ungapped_profile_diagonal_max;
   import updm_pkg::*;

   localparam int ITEM_TARGET    = 1550;
   localparam int QUIET_TAIL     = 200;
   localparam int SETTLE_CYCLES  = 150;
   localparam int HOLD_CYCLES    = 500;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // position, residue, score_byte
   logic                   req_tuser;   // operation
   logic                   req_tlast;   // last_residue
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [BYTE_W-1:0]      rsp_tdata;   // max_score
   logic                   csr_wr_en;
   logic [LEN_W-1:0]       csr_wr_data;
   int                     pending;
   int                     mismatches;

   // Stimulus bookkeeping: which score entries hold a loaded value
   bit               row_loaded [ALPHABET_SIZE][MAX_POSITIONS];
   int               ready_len [ALPHABET_SIZE];
   logic [LEN_W-1:0] cur_len;
   int               items_sent;
   int               stall_cycles;
   bit               quiet;
   bit               calm;
   bit               hold_ask;

   always #1 clock = ~clock;

   ungapped_profile_diagonal_max i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   updm_max_checker u_max_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .mismatches  (mismatches)
   );

   // Score bytes: any value, small negatives so diagonals climb, small positives, plus extremes
   function automatic logic [BYTE_W-1:0] pick_score();
      case ($urandom_range(0, 3))
         0: begin
            return BYTE_W'($urandom_range(0, 255));
         end
         1: begin
            return BYTE_W'($urandom_range(192, 255));
         end
         2: begin
            return BYTE_W'($urandom_range(0, 16));
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       return 8'h00;
               1:       return 8'h7F;
               2:       return 8'h80;
               default: return 8'hFF;
            endcase
         end
      endcase
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                               input logic [RES_W-1:0] res, input logic [BYTE_W-1:0] sbyte,
                               input logic last);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[TD_POS_LSB +: POS_W]   = pos;
      word[TD_RES_LSB +: RES_W]   = res;
      word[TD_BYTE_LSB +: BYTE_W] = sbyte;
      if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Load one score entry and extend the loaded prefix of its row
   task automatic load_score(input int res, input int pos, input logic [BYTE_W-1:0] sbyte,
                             input logic last);
      send_request(OP_LOAD, POS_W'(pos), RES_W'(res), sbyte, last);
      row_loaded[res][pos] = 1'b1;
      while (ready_len[res] < MAX_POSITIONS && row_loaded[res][ready_len[res]]) begin
         ready_len[res]++;
      end
   endtask

   // Score one residue whose row is loaded over the active length
   task automatic play_residue(input logic last);
      int span;
      int pick;
      int options [$];
      span = (cur_len > MAX_POSITIONS) ? MAX_POSITIONS : int'(cur_len);
      for (int r = 0; r < ALPHABET_SIZE; r++) begin
         if (ready_len[r] >= span) begin
            options.push_back(r);
         end
      end
      if (options.size() == 0 || (span <= 32 && $urandom_range(0, 3) == 0)) begin
         pick = $urandom_range(0, ALPHABET_SIZE - 1);
         while (ready_len[pick] < span) begin
            load_score(pick, ready_len[pick], pick_score(), $urandom_range(0, 3) == 0);
         end
      end else begin
         pick = options[$urandom_range(0, options.size() - 1)];
      end
      send_request(OP_RESIDUE, POS_W'($urandom_range(0, MAX_POSITIONS - 1)), RES_W'(pick),
                   BYTE_W'($urandom_range(0, 255)), last);
   endtask

   // Drop valid and wait until the block has nothing left in flight
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the length register while the block is idle
   task automatic program_length(input logic [LEN_W-1:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_len = value;
   endtask

   // One random phase: mixed loads and residues under one length
   task automatic run_phase(input logic [LEN_W-1:0] len_value, input int count);
      int pos;
      program_length(len_value);
      repeat (count) begin
         if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
            quiet = 1'b1;
         end
         if ($urandom_range(0, 9) < 3) begin
            pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 95)
                                              : $urandom_range(0, MAX_POSITIONS - 1);
            load_score($urandom_range(0, ALPHABET_SIZE - 1), pos, pick_score(),
                       $urandom_range(0, 3) == 0);
         end else begin
            play_residue($urandom_range(0, 3) == 0);
         end
      end
   endtask

   // Result side: random stall bursts, and one long hold-off on request
   initial begin : result_sink
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0] next_len;
      int               phase_no;
      int               sel;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_LOAD;
      req_tlast   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme score bytes, last mark on a load, saturation both ways
      program_length(11'd4);
      load_score(0, 0, 8'h80, 1'b1);
      load_score(0, 1, 8'hFF, 1'b0);
      load_score(0, 2, 8'h7F, 1'b0);
      load_score(0, 3, 8'h00, 1'b0);
      load_score(31, 0, 8'h01, 1'b0);
      load_score(31, 1, 8'h80, 1'b0);
      load_score(31, 2, 8'h80, 1'b0);
      load_score(31, 3, 8'h80, 1'b0);
      play_residue(1'b0);
      send_request(OP_RESIDUE, 10'h3FF, 5'd0, 8'hFF, 1'b1);
      send_request(OP_RESIDUE, 10'h000, 5'd31, 8'h00, 1'b1);
      load_score(31, MAX_POSITIONS - 1, 8'hAA, 1'b0);
      load_score(16, 512, 8'h55, 1'b1);
      send_request(OP_RESIDUE, 10'h155, 5'd31, 8'h5A, 1'b0);
      send_request(OP_RESIDUE, 10'h2AA, 5'd31, 8'hA5, 1'b1);
      send_request(OP_RESIDUE, 10'h000, 5'd0, 8'h00, 1'b0);

      // Length of one, changed in the middle of an open sequence
      program_length(11'd1);
      send_request(OP_RESIDUE, 10'h000, 5'd31, 8'h00, 1'b1);
      send_request(OP_RESIDUE, 10'h000, 5'd0, 8'h00, 1'b1);

      // Zero length: residues still count and a last one still reports
      program_length(11'd0);
      send_request(OP_RESIDUE, 10'h000, 5'd7, 8'h00, 1'b0);
      send_request(OP_RESIDUE, 10'h000, 5'd7, 8'h00, 1'b1);

      // Random phases, with full and above-table lengths forced early
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         if (phase_no == 4) begin
            // Long result stall while residues keep arriving
            calm = 1'b1;
            program_length(11'd6);
            hold_ask = 1'b1;
            repeat (16) play_residue(1'b1);
         end else begin
            sel = $urandom_range(0, 19);
            if (phase_no == 2) begin
               next_len = LEN_RESET;
            end else if (phase_no == 6) begin
               next_len = 11'h7FF;
            end else if (sel == 0) begin
               next_len = 11'd0;
            end else if (sel == 1) begin
               next_len = LEN_W'($urandom_range(MAX_POSITIONS, 2047));
            end else if (sel < 4) begin
               next_len = LEN_W'($urandom_range(33, 96));
            end else begin
               next_len = LEN_W'($urandom_range(1, 32));
            end
            run_phase(next_len, $urandom_range(6, 24));
         end
         phase_no++;
      end

      settle_block();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
